### rtl/assert_macros.svh
// assertion helpers, clocked on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge
`define SPP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// consequence holds in the same cycle as the trigger
`define SPP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequence holds in the cycle after the trigger
`define SPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/spp_pkg.sv
`default_nettype none
package spp_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned QueueDepth = 2;

  // classified request between front and back
  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 last;
    logic                 greater;
  } cls_item_t;

  // one result word
  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 last;
    logic                 overflow;
  } res_t;

endpackage
`default_nettype wire

### rtl/stable_pivot_partition_unit.sv
// a request not above the pivot is registered in the front queue, then in the output register
// throughput: one request per cycle through the front queue and back end, unless a held output or a flush stalls
// end of list: a setup state, then one held word per cycle from the buffer ram while the
//   output is not held; push sees full once the 2-entry front queue backs up during that flush
// reset: async active low; clears pivot, counts, flags and queues, not the ram
`default_nettype none
module stable_pivot_partition_unit #(
  parameter int unsigned BUFFER_DEPTH = 63
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic signed [31:0]  cfg_pivot_value_i,
  input  wire logic                push,
  output logic                     full,
  input  wire logic signed [31:0]  item_value_i,
  input  wire logic                item_last_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic signed [31:0]       out_value_o,
  output logic                     out_last_o,
  output logic                     out_overflow_o
);
  import spp_pkg::*;

  cls_item_t  fq_in, fq_out;
  logic       fq_push, fq_full, fq_valid, fq_pop;
  res_t       res;
  logic       res_valid;

  spp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_pivot_value_i (cfg_pivot_value_i),
    .push_i            (push),
    .item_value_i      (item_value_i),
    .item_last_i       (item_last_i),
    .q_full_i          (fq_full),
    .q_push_o          (fq_push),
    .q_item_o          (fq_in)
  );

  spp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .item_i  (fq_in),
    .full_o  (fq_full),
    .valid_o (fq_valid),
    .item_o  (fq_out),
    .pop_i   (fq_pop)
  );

  spp_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (fq_valid),
    .q_item_i    (fq_out),
    .q_pop_o     (fq_pop),
    .out_valid_o (res_valid),
    .out_o       (res),
    .pop_i       (pop)
  );

  assign full           = fq_full;
  assign empty          = !res_valid;
  assign out_value_o    = res.value;
  assign out_last_o     = res.last;
  assign out_overflow_o = res.overflow;

endmodule
`default_nettype wire

### rtl/spp_ram.sv
`default_nettype none
module spp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 63,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/spp_queue.sv
`default_nettype none
module spp_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire spp_pkg::cls_item_t  item_i,
  output logic                     full_o,
  output logic                     valid_o,
  output spp_pkg::cls_item_t       item_o,
  input  wire logic                pop_i
);
  import spp_pkg::*;

  localparam int unsigned PW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned NW = $clog2(QueueDepth + 1);

  cls_item_t       entry_q [QueueDepth];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == NW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

### rtl/spp_front.sv
`default_nettype none
module spp_front (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic signed [31:0]   cfg_pivot_value_i,
  input  wire logic                 push_i,
  input  wire logic signed [31:0]   item_value_i,
  input  wire logic                 item_last_i,
  input  wire logic                 q_full_i,
  output logic                      q_push_o,
  output spp_pkg::cls_item_t        q_item_o
);
  import spp_pkg::*;

  logic signed [31:0] pivot_q, pivot_d;

  assign cfg_ready_o = 1'b1;
  assign pivot_d     = (cfg_valid_i && cfg_ready_o) ? cfg_pivot_value_i : pivot_q;

  // classify against the pivot held when the request arrives
  assign q_push_o         = push_i && !q_full_i;
  assign q_item_o.value   = item_value_i;
  assign q_item_o.last    = item_last_i;
  assign q_item_o.greater = item_value_i > pivot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pivot_q <= '0;
    end else begin
      pivot_q <= pivot_d;
    end
  end

endmodule
`default_nettype wire

### rtl/spp_back.sv
`default_nettype none
`include "assert_macros.svh"
module spp_back #(
  parameter int unsigned BUFFER_DEPTH = 63
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_valid_i,
  input  wire spp_pkg::cls_item_t  q_item_i,
  output logic                     q_pop_o,
  output logic                     out_valid_o,
  output spp_pkg::res_t            out_o,
  input  wire logic                pop_i
);
  import spp_pkg::*;

  localparam int unsigned AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH_RD,
    ST_FLUSH_WR
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [AW-1:0]         idx_q, idx_d;
  res_t                  out_q, out_d;
  logic                  out_vld_q, out_vld_d;
  logic                  out_ok, out_load, has_room, fin;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DataWidth-1:0]  ram_rdata;

  spp_ram #(
    .WIDTH (DataWidth),
    .DEPTH (BUFFER_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (q_item_i.value),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_ok   = !out_vld_q || pop_i;
  assign has_room = count_q < CW'(BUFFER_DEPTH);
  assign fin      = (CW'(idx_q) + CW'(1)) == count_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    out_d     = out_q;
    out_load  = 1'b0;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    case (state_q)
      ST_RUN: begin
        if (q_valid_i && (q_item_i.greater || out_ok)) begin
          q_pop_o = 1'b1;
          if (q_item_i.greater) begin
            if (has_room) begin
              ram_we  = 1'b1;
              count_d = count_q + CW'(1);
            end else begin
              ovf_d = 1'b1;
            end
            if (q_item_i.last) begin
              idx_d   = '0;
              state_d = ST_FLUSH_RD;
            end
          end else begin
            out_load       = 1'b1;
            out_d.value    = q_item_i.value;
            out_d.last     = q_item_i.last && (count_q == '0);
            out_d.overflow = q_item_i.last && (count_q == '0) && ovf_q;
            if (q_item_i.last) begin
              if (count_q == '0) begin
                ovf_d = 1'b0;
              end else begin
                idx_d   = '0;
                state_d = ST_FLUSH_RD;
              end
            end
          end
        end
      end
      ST_FLUSH_RD: begin
        ram_re  = 1'b1;
        state_d = ST_FLUSH_WR;
      end
      ST_FLUSH_WR: begin
        if (out_ok) begin
          out_load       = 1'b1;
          out_d.value    = ram_rdata;
          out_d.last     = fin;
          out_d.overflow = fin && ovf_q;
          if (fin) begin
            count_d = '0;
            ovf_d   = 1'b0;
            idx_d   = '0;
            state_d = ST_RUN;
          end else begin
            idx_d     = idx_q + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + AW'(1);
          end
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  `SPP_ASSERT_ALWAYS(a_count_bounded, count_q <= CW'(BUFFER_DEPTH))
  `SPP_ASSERT_SAME(a_flush_nonempty, state_q != ST_RUN, count_q != '0)
  `SPP_ASSERT_NEXT(a_flush_done, state_q == ST_FLUSH_WR && out_ok && fin,
                   state_q == ST_RUN && count_q == '0 && !ovf_q && out_o.last)
  `SPP_ASSERT_SAME(a_no_pop_in_flush, state_q != ST_RUN, !q_pop_o)

endmodule
`default_nettype wire
